FILE: hdl/bsc_pkg.sv
// shared types, register indexes and wrapping arithmetic helpers
// for the barometric compensation core; no dependencies
`default_nettype none
package bsc_pkg;

	localparam int RawW   = 20;
	localparam int TempW  = 15;
	localparam int PressW = 25;
	localparam int DivSteps = 64;
	localparam int DenW   = 31;

	localparam logic [2:0] REG_T1    = 3'd0;
	localparam logic [2:0] REG_T2    = 3'd1;
	localparam logic [2:0] REG_T3    = 3'd2;
	localparam logic [2:0] REG_P1    = 3'd3;
	localparam logic [2:0] REG_P2_3  = 3'd4;
	localparam logic [2:0] REG_P4_5  = 3'd5;
	localparam logic [2:0] REG_P6_7  = 3'd6;
	localparam logic [2:0] REG_P8_9  = 3'd7;

	localparam logic signed [31:0] TempLo  = -32'sd4000;
	localparam logic signed [31:0] TempHi  = 32'sd8500;
	localparam logic signed [31:0] PressHi = 32'sd33554431;

	// side data that rides along the divider
	typedef struct packed {
		logic [TempW-1:0] temp;
		logic             dz;
		logic             qneg;
	} div_side_t;

	function automatic logic [63:0] sx64(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	// low 64 bits of a 64x64 product from 32-bit partial products
	function automatic logic [63:0] mul64(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] ll;
		logic [63:0] lh;
		logic [63:0] hl;
		logic [31:0] mid;
		ll  = a[31:0] * b[31:0];
		lh  = a[31:0] * b[63:32];
		hl  = a[63:32] * b[31:0];
		mid = lh[31:0] + hl[31:0];
		return ll + {mid, 32'd0};
	endfunction

endpackage
`default_nettype wire

FILE: hdl/barometric_sensor_compensation_core.sv
// an accepted item passes through 7 polynomial stages, 64 divider stages and 3 post
// stages to its result; throughput one item per cycle while the output is not stalled
// the whole pipeline advances together whenever the output register is free or taken
// reset clears the coefficient registers to zero and empties the pipeline
// depends on bsc_pkg and bsc_div
`default_nettype none
module barometric_sensor_compensation_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input item stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // raw_temperature[19:0], raw_pressure[39:20]
	// result item stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // temperature_centi[14:0], pressure_q17_8[39:15]
	output logic             m_tuser,   // divisor_zero
	// coefficient write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	import bsc_pkg::*;

	// calibration registers
	logic [15:0] t1_q, t2_q, t3_q, p1_q;
	logic [31:0] p23_q, p45_q, p67_q, p89_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t1_q  <= '0;
			t2_q  <= '0;
			t3_q  <= '0;
			p1_q  <= '0;
			p23_q <= '0;
			p45_q <= '0;
			p67_q <= '0;
			p89_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_T1:   t1_q  <= cfg_data[15:0];
				REG_T2:   t2_q  <= cfg_data[15:0];
				REG_T3:   t3_q  <= cfg_data[15:0];
				REG_P1:   p1_q  <= cfg_data[15:0];
				REG_P2_3: p23_q <= cfg_data;
				REG_P4_5: p45_q <= cfg_data;
				REG_P6_7: p67_q <= cfg_data;
				REG_P8_9: p89_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// coefficients sign extended to the pressure path width
	logic [63:0] k2, k3, k4, k5, k6, k7, k8, k9;
	assign k2 = sx64(p23_q[15:0]);
	assign k3 = sx64(p23_q[31:16]);
	assign k4 = sx64(p45_q[15:0]);
	assign k5 = sx64(p45_q[31:16]);
	assign k6 = sx64(p67_q[15:0]);
	assign k7 = sx64(p67_q[31:16]);
	assign k8 = sx64(p89_q[15:0]);
	assign k9 = sx64(p89_q[31:16]);

	// one enable for the whole pipeline: move while the output register can take a new item
	logic adv;
	logic v_s10;
	assign adv      = !v_s10 || m_tready;
	assign s_tready = adv;

	logic [RawW-1:0] rt, rp_in;
	assign rt    = s_tdata[19:0];
	assign rp_in = s_tdata[39:20];

	// stage 1: linear temperature term and squared offset
	logic [31:0] tdiff, tprod, ta_c, dlin, dsq_c;
	assign tdiff = {15'd0, rt[19:3]} - {15'd0, t1_q, 1'b0};
	assign tprod = tdiff * {{16{t2_q[15]}}, t2_q};
	assign ta_c  = $signed(tprod) >>> 11;
	assign dlin  = {16'd0, rt[19:4]} - {16'd0, t1_q};
	assign dsq_c = dlin * dlin;

	logic            v_s1;
	logic [31:0]     ta_s1, dsq_s1;
	logic [RawW-1:0] rp_s1;

	// stage 2: quadratic term, fine temperature
	logic [31:0] dsh, qprod, tb_c;
	assign dsh   = $signed(dsq_s1) >>> 12;
	assign qprod = dsh * {{16{t3_q[15]}}, t3_q};
	assign tb_c  = $signed(qprod) >>> 14;

	logic            v_s2;
	logic [31:0]     fine_s2;
	logic [RawW-1:0] rp_s2;

	// stage 3: centi-degrees with saturation, pressure offset term
	logic [31:0]      f5, tc_raw;
	logic [TempW-1:0] tc_sat;
	assign f5     = fine_s2 * 32'd5 + 32'd128;
	assign tc_raw = $signed(f5) >>> 8;
	always_comb begin
		if ($signed(tc_raw) < TempLo)      tc_sat = TempLo[TempW-1:0];
		else if ($signed(tc_raw) > TempHi) tc_sat = TempHi[TempW-1:0];
		else                               tc_sat = tc_raw[TempW-1:0];
	end

	logic             v_s3;
	logic [63:0]      x_s3;
	logic [TempW-1:0] tc_s3;
	logic [RawW-1:0]  rp_s3;

	// stage 4: first products of the offset
	logic             v_s4;
	logic [63:0]      xx_s4, xk5_s4, xk2_s4;
	logic [TempW-1:0] tc_s4;
	logic [RawW-1:0]  rp_s4;

	// stage 5: numerator correction and divisor polynomial
	logic [63:0] y_c, a_c, xk3, xk3_sh;
	assign y_c    = mul64(xx_s4, k6) + (xk5_s4 << 17) + (k4 << 35);
	assign xk3    = mul64(xx_s4, k3);
	// arithmetic shift kept apart from the unsigned sum
	assign xk3_sh = $signed(xk3) >>> 8;
	assign a_c    = xk3_sh + (xk2_s4 << 12);

	logic             v_s5;
	logic [63:0]      y_s5, a_s5;
	logic [TempW-1:0] tc_s5;
	logic [RawW-1:0]  rp_s5;

	// stage 6: scaled divisor and dividend
	logic [63:0] bsc_c, xd_c, pn_c, num_c;
	assign bsc_c = mul64(64'h0000_8000_0000_0000 + a_s5, {48'd0, p1_q});
	assign xd_c  = $signed(bsc_c) >>> 33;
	assign pn_c  = 64'd1048576 - {44'd0, rp_s5};
	assign num_c = mul64((pn_c << 31) - y_s5, 64'd3125);

	logic             v_s6;
	logic [63:0]      xd_s6, num_s6;
	logic [TempW-1:0] tc_s6;

	// stage 7: magnitudes and signs for the divider
	logic             v_s7;
	logic [63:0]      nm_s7;
	logic [DenW-1:0]  dm_s7;
	div_side_t        side_s7;
	logic [63:0]      xd_mag;
	assign xd_mag = xd_s6[63] ? 64'd0 - xd_s6 : xd_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ta_s1   <= ta_c;
			dsq_s1  <= dsq_c;
			rp_s1   <= rp_in;

			fine_s2 <= ta_s1 + tb_c;
			rp_s2   <= rp_s1;

			x_s3    <= {{32{fine_s2[31]}}, fine_s2} - 64'd128000;
			tc_s3   <= tc_sat;
			rp_s3   <= rp_s2;

			xx_s4   <= mul64(x_s3, x_s3);
			xk5_s4  <= mul64(x_s3, k5);
			xk2_s4  <= mul64(x_s3, k2);
			tc_s4   <= tc_s3;
			rp_s4   <= rp_s3;

			y_s5    <= y_c;
			a_s5    <= a_c;
			tc_s5   <= tc_s4;
			rp_s5   <= rp_s4;

			xd_s6   <= xd_c;
			num_s6  <= num_c;
			tc_s6   <= tc_s5;

			nm_s7        <= num_s6[63] ? 64'd0 - num_s6 : num_s6;
			dm_s7        <= xd_mag[DenW-1:0];
			side_s7.temp <= tc_s6;
			side_s7.dz   <= xd_s6 == 64'd0;
			side_s7.qneg <= num_s6[63] ^ xd_s6[63];
		end
	end

	// truncating division, one quotient bit per stage
	logic        v_dv;
	logic [63:0] q_dv;
	div_side_t   side_dv;

	bsc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.in_valid (v_s7),
		.nm       (nm_s7),
		.dm       (dm_s7),
		.side_in  (side_s7),
		.out_valid(v_dv),
		.quo      (q_dv),
		.side_out (side_dv)
	);

	// stage 8: signed quotient, its scaled copy and the linear correction
	logic [63:0] p_c;
	assign p_c = side_dv.qneg ? 64'd0 - q_dv : q_dv;

	logic             v_s8;
	logic [63:0]      p_s8, ps_s8, g_s8;
	logic [TempW-1:0] tc_s8;
	logic             dz_s8;

	// stage 9: square of the scaled pressure
	logic             v_s9;
	logic [63:0]      p_s9, pp_s9, g_s9;
	logic [TempW-1:0] tc_s9;
	logic             dz_s9;

	// stage 10 (output register): quadratic correction, offset and saturation
	logic [63:0]       e_c, s_sh, s_c;
	logic [PressW-1:0] pr_sat;
	assign e_c  = $signed(mul64(k9, pp_s9)) >>> 25;
	assign s_sh = $signed(p_s9 + e_c + g_s9) >>> 8;
	assign s_c  = s_sh + (k7 << 4);
	always_comb begin
		if (dz_s9)                            pr_sat = '0;
		else if ($signed(s_c[31:0]) < 32'sd0) pr_sat = '0;
		else if ($signed(s_c[31:0]) > PressHi) pr_sat = PressHi[PressW-1:0];
		else                                  pr_sat = s_c[PressW-1:0];
	end

	logic [TempW-1:0]  tc_s10;
	logic [PressW-1:0] pr_s10;
	logic              dz_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else if (adv) begin
			v_s8  <= v_dv;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s8   <= p_c;
			ps_s8  <= $signed(p_c) >>> 13;
			g_s8   <= $signed(mul64(k8, p_c)) >>> 19;
			tc_s8  <= side_dv.temp;
			dz_s8  <= side_dv.dz;

			p_s9   <= p_s8;
			pp_s9  <= mul64(ps_s8, ps_s8);
			g_s9   <= g_s8;
			tc_s9  <= tc_s8;
			dz_s9  <= dz_s8;

			tc_s10 <= tc_s9;
			pr_s10 <= pr_sat;
			dz_s10 <= dz_s9;
		end
	end

	assign m_tvalid = v_s10;
	assign m_tdata  = {pr_s10, tc_s10};
	assign m_tuser  = dz_s10;

endmodule
`default_nettype wire

FILE: hdl/bsc_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on bsc_pkg
`default_nettype none
module bsc_div (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   en,
	input  wire logic                   in_valid,
	input  wire logic [63:0]            nm,
	input  wire logic [bsc_pkg::DenW-1:0] dm,
	input  wire bsc_pkg::div_side_t     side_in,
	output logic                        out_valid,
	output logic [63:0]                 quo,
	output bsc_pkg::div_side_t          side_out
);
	import bsc_pkg::*;

	logic              vld_s  [0:DivSteps];
	logic [63:0]       num_s  [0:DivSteps];
	logic [DenW:0]     rem_s  [0:DivSteps];
	logic [DenW-1:0]   den_s  [0:DivSteps];
	div_side_t         side_s [0:DivSteps];

	assign vld_s[0]  = in_valid;
	assign num_s[0]  = nm;
	assign rem_s[0]  = '0;
	assign den_s[0]  = dm;
	assign side_s[0] = side_in;

	for (genvar i = 0; i < DivSteps; i++) begin : g_step
		logic [DenW:0] trial;
		logic          fits;
		assign trial = {rem_s[i][DenW-1:0], num_s[i][63]};
		assign fits  = trial >= {1'b0, den_s[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (en) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1]  <= fits ? trial - {1'b0, den_s[i]} : trial;
				num_s[i+1]  <= {num_s[i][62:0], fits};
				den_s[i+1]  <= den_s[i];
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_valid = vld_s[DivSteps];
	assign quo       = num_s[DivSteps];
	assign side_out  = side_s[DivSteps];

endmodule
`default_nettype wire

FILE: test/bsc_checker.sv
// scoreboard for the barometric compensation core: tracks coefficient writes,
// predicts each compensated result and compares it with the output stream
// depends on bsc_pkg for widths and register indexes
module bsc_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [39:0] s_tdata,
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [39:0] m_tdata,
	input  wire logic        m_tuser,
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	output int               errors,
	output int               checked,
	output int               dz_seen,
	output int               clamped_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import bsc_pkg::*;

	typedef struct packed {
		logic signed [TempW-1:0] temp;
		logic [PressW-1:0]       press;
		logic                    dz;
	} reading_t;

	logic [15:0] t1, t2, t3, p1;
	logic [31:0] p23, p45, p67, p89;
	reading_t    pending_q[$];

	function automatic logic [31:0] sra32(input logic [31:0] v, input int n);
		logic signed [31:0] s;
		s = v;
		return s >>> n;
	endfunction

	function automatic logic [63:0] sra64(input logic [63:0] v, input int n);
		logic signed [63:0] s;
		s = v;
		return s >>> n;
	endfunction

	function automatic logic [63:0] ext16(input logic [15:0] v);
		return {{48{v[15]}}, v};
	endfunction

	// signed division truncating toward zero, done on magnitudes
	function automatic logic [63:0] div_trunc(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] nm, dm, q;
		nm = num[63] ? -num : num;
		dm = den[63] ? -den : den;
		q  = nm / dm;
		return (num[63] != den[63]) ? -q : q;
	endfunction

	function automatic reading_t compensate(input logic [19:0] rt, input logic [19:0] rp);
		logic [31:0] rt32, c1, c2, c3, w, d, ta, tb, fine;
		logic [63:0] x, y, p, ps, e, g, w64;
		logic signed [31:0] tc, pv;
		reading_t r;
		// temperature, wrapping at 32 bits
		rt32 = {12'd0, rt};
		c1   = {16'd0, t1};
		c2   = {{16{t2[15]}}, t2};
		c3   = {{16{t3[15]}}, t3};
		w    = (rt32 >> 3) - (c1 << 1);
		w    = w * c2;
		ta   = sra32(w, 11);
		d    = (rt32 >> 4) - c1;
		w    = sra32(d * d, 12);
		w    = w * c3;
		tb   = sra32(w, 14);
		fine = ta + tb;
		tc   = sra32(fine * 32'd5 + 32'd128, 8);
		if (tc < TempLo) tc = TempLo;
		if (tc > TempHi) tc = TempHi;
		r.temp = tc[TempW-1:0];
		// pressure, wrapping at 64 bits
		x   = {{32{fine[31]}}, fine} - 64'd128000;
		y   = x * x * ext16(p67[15:0]);
		y   = y + ((x * ext16(p45[31:16])) << 17);
		y   = y + (ext16(p45[15:0]) << 35);
		w64 = sra64(x * x * ext16(p23[31:16]), 8);
		x   = w64 + ((x * ext16(p23[15:0])) << 12);
		x   = ((64'd1 << 47) + x) * {48'd0, p1};
		x   = sra64(x, 33);
		r.dz    = (x == 64'd0);
		r.press = '0;
		if (!r.dz) begin
			p  = 64'd1048576 - {44'd0, rp};
			p  = div_trunc(((p << 31) - y) * 64'd3125, x);
			ps = sra64(p, 13);
			e  = sra64(ext16(p89[31:16]) * ps * ps, 25);
			g  = sra64(ext16(p89[15:0]) * p, 19);
			p  = sra64(p + e + g, 8) + (ext16(p67[31:16]) << 4);
			pv = p[31:0];
			if (pv < 0) r.press = '0;
			else if (pv > PressHi) r.press = '1;
			else r.press = pv[PressW-1:0];
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reading_t want, got;
		if (!arst_n) begin
			{t1, t2, t3, p1} = '0;
			{p23, p45, p67, p89} = '0;
			pending_q.delete();
			errors = 0;
			checked = 0;
			dz_seen = 0;
			clamped_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_T1:   t1  = cfg_data[15:0];
					REG_T2:   t2  = cfg_data[15:0];
					REG_T3:   t3  = cfg_data[15:0];
					REG_P1:   p1  = cfg_data[15:0];
					REG_P2_3: p23 = cfg_data;
					REG_P4_5: p45 = cfg_data;
					REG_P6_7: p67 = cfg_data;
					REG_P8_9: p89 = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				pending_q.push_back(compensate(s_tdata[19:0], s_tdata[39:20]));
			if (m_tvalid && m_tready) begin
				got.temp  = m_tdata[14:0];
				got.press = m_tdata[39:15];
				got.dz    = m_tuser;
				if (pending_q.size() == 0) begin
					errors++;
					$display("%0t: result with nothing expected: temp %0d press %0d dz %0b",
						$time, got.temp, got.press, got.dz);
				end else begin
					want = pending_q.pop_front();
					checked++;
					if (want.dz) dz_seen++;
					if (!want.dz && (want.press == '0 || want.press == '1)) clamped_seen++;
					if (got.temp !== want.temp) begin
						errors++;
						$display("%0t: temperature expected %0d actual %0d",
							$time, want.temp, got.temp);
					end
					if (got.press !== want.press) begin
						errors++;
						$display("%0t: pressure expected %0d actual %0d",
							$time, want.press, got.press);
					end
					if (got.dz !== want.dz) begin
						errors++;
						$display("%0t: divisor_zero expected %0b actual %0b",
							$time, want.dz, got.dz);
					end
				end
			end
		end
	end

	function automatic int outstanding();
		return pending_q.size();
	endfunction

endmodule

FILE: test/tb_barometric_sensor_compensation_core.sv
// stimulus and verdict for the barometric compensation core: coefficient
// phases, bursty input items and a stalling receiver; depends on bsc_pkg,
// the core and bsc_checker
module tb_barometric_sensor_compensation_core;
	timeunit 1ns;
	timeprecision 1ps;
	import bsc_pkg::*;

	localparam int CycleLimit = 400000;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid, s_tready;
	logic [39:0] s_tdata;
	logic        m_tvalid, m_tready;
	logic [39:0] m_tdata;
	logic        m_tuser;
	logic        cfg_valid, cfg_ready;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	int errors, checked, dz_seen, clamped_seen;
	int sent, received, cycles;
	int burst_left;
	int stall_mode;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_T1;
		cfg_data = '0;
	end

	always #6 clk = ~clk;

	barometric_sensor_compensation_core dut (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	bsc_checker scoreboard (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.errors, .checked, .dz_seen, .clamped_seen
	);

	// watchdog and result counting
	always @(posedge clk) begin
		cycles++;
		if (m_tvalid && m_tready) received++;
		if (cycles > CycleLimit) begin
			$display("timeout after %0d cycles, %0d of %0d results in", cycles, received, sent);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver: stall pattern changes every so often, sometimes never stalling
	always @(negedge clk) begin
		if (cycles % 150 == 0) stall_mode = $urandom_range(0, 3);
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 9) < 7);
			2: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= ((cycles / 5) % 3 != 0);
		endcase
	end

	// one input item, sent in bursts with random gaps between them
	task automatic send_item(input logic [19:0] raw_t, input logic [19:0] raw_p);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		s_tvalid = 1'b1;
		s_tdata = {raw_p, raw_t};
		do @(posedge clk); while (!s_tready);
		sent++;
		burst_left--;
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	// all items back out of the pipeline
	task automatic drain();
		while (received != sent) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic load_coeffs(input logic [15:0] c[12]);
		write_reg(REG_T1, {16'd0, c[0]});
		write_reg(REG_T2, {16'd0, c[1]});
		write_reg(REG_T3, {16'd0, c[2]});
		write_reg(REG_P1, {16'd0, c[3]});
		write_reg(REG_P2_3, {c[5], c[4]});
		write_reg(REG_P4_5, {c[7], c[6]});
		write_reg(REG_P6_7, {c[9], c[8]});
		write_reg(REG_P8_9, {c[11], c[10]});
	endtask

	// typical factory calibration, used as the centre of the random phases
	function automatic void nominal(output logic [15:0] c[12]);
		c = '{16'd27504, 16'd26435, -16'sd1000, 16'd36477, -16'sd10685, 16'd3024,
			16'd2855, 16'd140, -16'sd7, 16'd15500, -16'sd14600, 16'd6000};
	endfunction

	task automatic directed_items();
		send_item(20'd0, 20'd0);
		send_item(20'hFFFFF, 20'hFFFFF);
		send_item(20'd0, 20'hFFFFF);
		send_item(20'hFFFFF, 20'd0);
		send_item(20'hAAAAA, 20'h55555);
		send_item(20'h55555, 20'hAAAAA);
		send_item(20'd519888, 20'd415148);
		send_item(20'd1, 20'd1);
	endtask

	// mostly plausible readings near a working point, some anywhere
	task automatic random_items(input int count);
		logic [19:0] rt, rp;
		repeat (count) begin
			if ($urandom_range(0, 4) != 0) begin
				rt = 20'd519888 + 20'($signed($urandom_range(0, 131071)) - 65536);
				rp = 20'($urandom_range(200000, 700000));
			end else begin
				rt = 20'($urandom);
				rp = 20'($urandom);
			end
			send_item(rt, rp);
		end
	endtask

	initial begin
		logic [15:0] c[12];
		burst_left = 0;
		stall_mode = 0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// coefficients at reset: divisor is zero
		directed_items();
		drain();

		// nominal calibration
		nominal(c);
		load_coeffs(c);
		directed_items();
		drain();

		// extremes: all coefficients at their top, then at their bottom with P1 at one
		foreach (c[i]) c[i] = (i == 0 || i == 3) ? 16'hFFFF : 16'h7FFF;
		load_coeffs(c);
		directed_items();
		drain();
		foreach (c[i]) c[i] = (i == 0 || i == 3) ? 16'h0000 : 16'h8000;
		c[3] = 16'd1;
		load_coeffs(c);
		directed_items();
		drain();

		// random phases: perturbed nominal, then fully random coefficients
		for (int ph = 0; ph < 6; ph++) begin
			nominal(c);
			foreach (c[i])
				if (ph >= 4 || $urandom_range(0, 2) == 0)
					c[i] = (ph >= 4) ? 16'($urandom) : c[i] + 16'($urandom_range(0, 255)) - 16'd128;
			load_coeffs(c);
			random_items(175);
			drain();
		end

		repeat (100) @(posedge clk);
		$display("%0d items checked over 10 coefficient sets, %0d with a zero divisor,",
			checked, dz_seen);
		$display("%0d with pressure pinned at a range limit", clamped_seen);
		if (errors == 0 && received == sent) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
